// File: hw/rtl/midpoint_circle_rasterizer_core_assert.svh
// assertion macros shared by the rtl files
`ifndef MIDPOINT_CIRCLE_RASTERIZER_CORE_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define MCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define MCR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/mcr_pkg.sv
package mcr_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned OffW    = 15;
  localparam int unsigned RadiusW = 14;
  localparam int unsigned DecW    = 20;
  localparam int unsigned IdxW    = 3;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef struct packed {
    logic                      operation;
    logic signed [CoordW-1:0]  center_x;
    logic signed [CoordW-1:0]  center_y;
    logic [RadiusW-1:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0]  point_x;
    logic signed [CoordW-1:0]  point_y;
    logic                      last;
    logic                      finished;
  } out_item_t;

  // one group of eight points waiting to be emitted
  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [OffW-1:0]   ox;
    logic [OffW-1:0]   oy;
    logic              done;
  } group_t;

  // queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// File: hw/rtl/mcr_front.sv
module mcr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mcr_pkg::in_item_t in_item_i,
  input  mcr_pkg::q_status_t q_status_i,
  output logic              push_o,
  output mcr_pkg::group_t   push_data_o
);
  import mcr_pkg::*;

  logic [CoordW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [OffW-1:0]   ox_q, ox_d, oy_q, oy_d;
  logic [DecW-1:0]   dec_q, dec_d;
  logic              accept, running, dec_pos;
  logic [OffW-1:0]   x1, y1;
  logic [DecW-1:0]   diff;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign running    = ox_q < oy_q;
  assign dec_pos    = !dec_q[DecW-1] && (dec_q != '0);
  assign x1         = ox_q + OffW'(1);
  assign y1         = oy_q - OffW'(1);
  assign diff       = {{(DecW-OffW){1'b0}}, x1} - {{(DecW-OffW){1'b0}}, y1};

  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    ox_d   = ox_q;
    oy_d   = oy_q;
    dec_d  = dec_q;
    push_o = 1'b0;
    if (accept) begin
      unique case (op_e'(in_item_i.operation))
        OP_START: begin
          cx_d   = in_item_i.center_x;
          cy_d   = in_item_i.center_y;
          ox_d   = '0;
          oy_d   = {{(OffW-RadiusW){1'b0}}, in_item_i.radius};
          dec_d  = DecW'(3) - {{(DecW-RadiusW-1){1'b0}}, in_item_i.radius, 1'b0};
          push_o = 1'b1;
        end
        OP_ADVANCE: begin
          // nothing happens once the octant is done
          if (running) begin
            ox_d   = x1;
            push_o = 1'b1;
            if (dec_pos) begin
              oy_d  = y1;
              dec_d = dec_q + {diff[DecW-3:0], 2'b00} + DecW'(6);
            end else begin
              dec_d = dec_q + {{(DecW-OffW-2){1'b0}}, x1, 2'b00} + DecW'(6);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign push_data_o = '{cx: cx_d, cy: cy_d, ox: ox_d, oy: oy_d, done: !(ox_d < oy_d)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
      dec_q <= '0;
    end else begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      dec_q <= dec_d;
    end
  end

endmodule

// File: hw/rtl/mcr_queue.sv
`include "midpoint_circle_rasterizer_core_assert.svh"

module mcr_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mcr_pkg::group_t    push_data_i,
  input  logic               pop_i,
  output mcr_pkg::group_t    head_o,
  output mcr_pkg::q_status_t status_o
);
  import mcr_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  `MCR_ASSERT_NEVER(a_no_overflow, push_i && status_o.full, "push into full queue")
  `MCR_ASSERT_NEVER(a_no_underflow, pop_i && status_o.empty, "pop from empty queue")
  `MCR_ASSERT(a_cnt_tracks, do_push && !do_pop |=> cnt_q == $past(cnt_q) + CntW'(1), "count lost a push")

endmodule

// File: hw/rtl/mcr_back.sv
`include "midpoint_circle_rasterizer_core_assert.svh"

module mcr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcr_pkg::group_t     head_i,
  input  mcr_pkg::q_status_t  q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mcr_pkg::out_item_t  out_item_o
);
  import mcr_pkg::*;

  logic [IdxW-1:0]   idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              load;
  logic [CoordW-1:0] ox16, oy16, nx, ny, ax, ay;

  // output register may refill when empty or being taken
  assign load  = !q_status_i.empty && (!out_valid_q || out_ready_i);
  assign pop_o = load && (idx_q == IdxW'(7));

  always_comb begin
    ox16 = {1'b0, head_i.ox};
    oy16 = {1'b0, head_i.oy};
    nx   = idx_q[0] ? CoordW'(0) - ox16 : ox16;
    ny   = idx_q[1] ? CoordW'(0) - oy16 : oy16;
    ax   = idx_q[2] ? ny : nx;
    ay   = idx_q[2] ? nx : ny;
    out_d.point_x  = head_i.cx + ax;
    out_d.point_y  = head_i.cy + ay;
    out_d.last     = (idx_q == IdxW'(7));
    out_d.finished = head_i.done;
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = idx_q + IdxW'(1);
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `MCR_ASSERT(a_group_held, idx_q != '0 |-> !q_status_i.empty, "group left queue mid-emission")
  `MCR_ASSERT(a_pop_wraps, pop_o |=> idx_q == '0, "index not back to zero after group")
  `MCR_ASSERT(a_last_marks_pop, load |=> out_valid_q && (out_q.last == $past(pop_o)), "last flag out of step with pop")

endmodule

// File: hw/rtl/midpoint_circle_rasterizer_core.sv
// Midpoint circle point generator. A start transaction (operation 0) loads a
// center and radius and yields the first group of eight symmetric points; an
// advance transaction (operation 1) steps the octant one x position and yields
// the next group, or nothing once x has reached y. Every group is eight output
// transactions, last set on the eighth, finished set on each point of the
// final group. The single result channel gives one point per cycle while
// out_ready_i is high; each group passes through the queue and then the
// output register before its first point shows. Input items are taken at one
// per cycle until QueueDepth groups, the one in emission included, are queued.
module midpoint_circle_rasterizer_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mcr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mcr_pkg::out_item_t out_item_o
);
  import mcr_pkg::*;

  logic      push, pop;
  group_t    push_data, head;
  q_status_t q_status;

  mcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_data_o(push_data)
  );

  mcr_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  mcr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
